[rtl/stl_pkg.sv]
// Shared definitions for the script token lexer: sizes, token and error codes,
// character codes, keyword table and the controller/datapath command structs.
// No dependencies.
package stl_pkg;

  localparam int MAX_NAME   = 32;
  localparam int LINE_BITS  = 16;
  localparam int BYTE_W     = 8;
  localparam int TOKEN_W    = 5;
  localparam int LINE_OUT_W = 16;
  localparam int ERR_W      = 2;
  localparam int NAME_LEN_W = $clog2(MAX_NAME + 1);
  localparam int NAME_IDX_W = $clog2(MAX_NAME);
  localparam int NUM_KW     = 8;
  localparam int KW_COLS    = 16;
  localparam int KW_COL_W   = 4;

  typedef logic [TOKEN_W-1:0] token_t;
  typedef logic [ERR_W-1:0]   err_t;

  localparam token_t TK_VAR       = 5'd0;
  localparam token_t TK_BG        = 5'd1;
  localparam token_t TK_EXIT      = 5'd7;
  localparam token_t TK_BRACE_OP  = 5'd9;
  localparam token_t TK_BRACE_CL  = 5'd10;
  localparam token_t TK_EQ        = 5'd11;
  localparam token_t TK_NEW_LINE  = 5'd12;
  localparam token_t TK_COMMA     = 5'd13;
  localparam token_t TK_DOT       = 5'd14;
  localparam token_t TK_TEXT_LINE = 5'd15;
  localparam token_t TK_ERROR     = 5'd16;

  localparam err_t ERR_NONE   = 2'd0;
  localparam err_t ERR_SYMBOL = 2'd1;
  localparam err_t ERR_TEXT   = 2'd2;
  localparam err_t ERR_LONG   = 2'd3;

  localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL       = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SP       = 8'h20;
  localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
  localparam logic [BYTE_W-1:0] CH_HASH     = 8'h23;
  localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_EQ       = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_BRACE_OP = 8'h7B;
  localparam logic [BYTE_W-1:0] CH_BRACE_CL = 8'h7D;

  // keyword rows, first character in the top byte, padded with spaces
  localparam logic [KW_COLS*BYTE_W-1:0] KW_TEXT [NUM_KW] = '{
    "background      ",
    "foreground      ",
    "text            ",
    "put             ",
    "persona         ",
    "path            ",
    "exit            ",
    "name            "
  };
  localparam logic [KW_COL_W-1:0] KW_LEN [NUM_KW] = '{
    4'd10, 4'd10, 4'd4, 4'd3, 4'd7, 4'd4, 4'd4, 4'd4
  };

  typedef enum logic [3:0] {
    BC_ALNUM    = 4'd0,
    BC_SPACE    = 4'd1,
    BC_HASH     = 4'd2,
    BC_QUOTE    = 4'd3,
    BC_NL       = 4'd4,
    BC_BRACE_OP = 4'd5,
    BC_BRACE_CL = 4'd6,
    BC_EQ       = 4'd7,
    BC_COMMA    = 4'd8,
    BC_DOT      = 4'd9,
    BC_OTHER    = 4'd10
  } byte_class_t;

  typedef enum logic [1:0] {
    BS_NONE = 2'd0,
    BS_ITEM = 2'd1,
    BS_NAME = 2'd2
  } bsel_t;

  typedef struct packed {
    logic   use_hold;
    logic   hold_load;
    logic   name_add;
    logic   name_clear;
    logic   count_line;
    logic   set_text_start;
    logic   line_reset;
    logic   rd_start;
    logic   rd_advance;
    logic   emit;
    token_t emit_kind;
    err_t   emit_err;
    bsel_t  emit_bsel;
    logic   emit_start_line;
    logic   emit_last;
  } cmd_t;

  typedef struct packed {
    byte_class_t cur_class;
    logic        cur_eoi;
    logic        name_nz;
    logic        name_full;
    logic        kw_match;
    token_t      kw_kind;
    logic        flush_last;
    logic        can_emit;
  } status_t;

endpackage

[rtl/stl_if.sv]
// Valid/ready channel interfaces for the lexer input bytes and result tokens.
// Depends on stl_pkg.
interface stl_in_if;
  import stl_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_input;
  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

interface stl_out_if;
  import stl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [TOKEN_W-1:0]    token_kind;
  logic [BYTE_W-1:0]     text_byte;
  logic                  has_byte;
  logic [LINE_OUT_W-1:0] line_number;
  logic [ERR_W-1:0]      error_code;
  logic                  last;
  modport source (output valid, token_kind, text_byte, has_byte, line_number, error_code,
                  last, input ready);
  modport sink   (input valid, token_kind, text_byte, has_byte, line_number, error_code,
                  last, output ready);
endinterface

[rtl/script_token_lexer_unit.sv]
// Script token lexer top level: joins stl_ctrl and stl_datapath to the channels.
// Depends on stl_pkg, stl_if, stl_ctrl, stl_datapath.
//
//  channel   dir  payload                                              transfer
//  in_chan   in   in_byte, end_of_input                                valid & ready
//  out_chan  out  token_kind, text_byte, has_byte, line_number,        valid & ready
//                 error_code, last
//
// An item giving at most one token is handled straight from the input while the output register is free;
// bytes of quoted text stream at one per cycle while the output register is free.
// A pending name flush emits one VAR token per name byte (or one keyword token), then the
// trailing delimiter token, if any, or EXIT; input is held off during it.
// An item that would emit a token while the output register is still full waits in a hold register.
// Synchronous active-low reset; the name buffer needs no clearing pass.
module script_token_lexer_unit (
  input  logic      clk,
  input  logic      rst_n,
  stl_in_if.sink    in_chan,
  stl_out_if.source out_chan
);
  import stl_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  stl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  stl_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_chan.in_byte),
    .in_eoi          (in_chan.end_of_input),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_token_kind  (out_chan.token_kind),
    .out_text_byte   (out_chan.text_byte),
    .out_has_byte    (out_chan.has_byte),
    .out_line_number (out_chan.line_number),
    .out_error_code  (out_chan.error_code),
    .out_last        (out_chan.last)
  );

  assign in_chan.ready = in_ready;

endmodule

[rtl/stl_ctrl.sv]
// Lexer controller: scan mode, sequencing of name flush and trailing token.
// Depends on stl_pkg; drives cmd_t to stl_datapath, reads status_t.
module stl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stl_pkg::status_t  status,
  output stl_pkg::cmd_t     cmd
);
  import stl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_HOLD  = 4'b0010,
    ST_FLUSH = 4'b0100,
    ST_TAIL  = 4'b1000
  } state_t;

  typedef enum logic [3:0] {
    MD_IDLE    = 4'b0001,
    MD_COMMENT = 4'b0010,
    MD_TEXT    = 4'b0100,
    MD_DROP    = 4'b1000
  } mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   tail_v_r, tail_v_nxt;
  token_t tail_kind_r, tail_kind_nxt;
  logic   tail_count_r, tail_count_nxt;

  logic   go;
  logic   p_emit, p_last, p_start_line, p_count, p_add, p_clear;
  logic   p_text_start, p_reset, p_flush, p_tail_v, p_tail_count;
  token_t p_kind, p_tail_kind, tok;
  err_t   p_err;
  bsel_t  p_bsel;
  mode_t  p_mode;
  logic   has_tok;

  // per-item plan
  always_comb begin
    p_emit       = 1'b0;
    p_last       = 1'b1;
    p_start_line = 1'b0;
    p_count      = 1'b0;
    p_add        = 1'b0;
    p_clear      = 1'b0;
    p_text_start = 1'b0;
    p_reset      = 1'b0;
    p_flush      = 1'b0;
    p_tail_v     = 1'b0;
    p_tail_count = 1'b0;
    p_kind       = TK_VAR;
    p_tail_kind  = TK_VAR;
    p_err        = ERR_NONE;
    p_bsel       = BS_NONE;
    p_mode       = mode_r;
    has_tok      = 1'b1;
    case (status.cur_class)
      BC_BRACE_OP: tok = TK_BRACE_OP;
      BC_BRACE_CL: tok = TK_BRACE_CL;
      BC_EQ:       tok = TK_EQ;
      BC_COMMA:    tok = TK_COMMA;
      BC_DOT:      tok = TK_DOT;
      BC_NL:       tok = TK_NEW_LINE;
      default: begin
        tok     = TK_VAR;
        has_tok = 1'b0;
      end
    endcase
    if (status.cur_eoi) begin
      if (mode_r == MD_TEXT) begin
        p_emit       = 1'b1;
        p_kind       = TK_ERROR;
        p_err        = ERR_TEXT;
        p_start_line = 1'b1;
        p_last       = 1'b0;
        p_tail_v     = 1'b1;
        p_tail_kind  = TK_EXIT;
      end else if (mode_r == MD_IDLE && status.name_nz) begin
        p_flush     = 1'b1;
        p_tail_v    = 1'b1;
        p_tail_kind = TK_EXIT;
      end else begin
        p_emit  = 1'b1;
        p_kind  = TK_EXIT;
        p_reset = 1'b1;
        p_clear = 1'b1;
        p_mode  = MD_IDLE;
      end
    end else begin
      case (mode_r)
        MD_DROP: begin
        end
        MD_COMMENT: begin
          if (status.cur_class == BC_NL) begin
            p_emit  = 1'b1;
            p_kind  = TK_NEW_LINE;
            p_count = 1'b1;
            p_mode  = MD_IDLE;
          end else if (status.cur_class == BC_HASH) begin
            p_mode = MD_IDLE;
          end
        end
        MD_TEXT: begin
          p_emit = 1'b1;
          p_kind = TK_TEXT_LINE;
          if (status.cur_class == BC_QUOTE) begin
            p_mode = MD_IDLE;
          end else begin
            p_bsel  = BS_ITEM;
            p_count = (status.cur_class == BC_NL);
          end
        end
        default: begin
          case (status.cur_class)
            BC_ALNUM: begin
              if (status.name_full) begin
                p_emit  = 1'b1;
                p_kind  = TK_ERROR;
                p_err   = ERR_LONG;
                p_clear = 1'b1;
                p_mode  = MD_DROP;
              end else begin
                p_add = 1'b1;
              end
            end
            BC_OTHER: begin
              p_emit  = 1'b1;
              p_kind  = TK_ERROR;
              p_err   = ERR_SYMBOL;
              p_clear = 1'b1;
              p_mode  = MD_DROP;
            end
            default: begin
              if (status.cur_class == BC_HASH) begin
                p_mode = MD_COMMENT;
              end else if (status.cur_class == BC_QUOTE) begin
                p_mode       = MD_TEXT;
                p_text_start = 1'b1;
              end
              if (status.name_nz) begin
                p_flush      = 1'b1;
                p_tail_v     = has_tok;
                p_tail_kind  = tok;
                p_tail_count = (status.cur_class == BC_NL);
              end else if (has_tok) begin
                p_emit  = 1'b1;
                p_kind  = tok;
                p_count = (status.cur_class == BC_NL);
              end
            end
          endcase
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.emit_bsel  = BS_NONE;
    cmd.emit_kind  = TK_VAR;
    cmd.emit_err   = ERR_NONE;
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    tail_v_nxt     = tail_v_r;
    tail_kind_nxt  = tail_kind_r;
    tail_count_nxt = tail_count_r;
    in_ready       = (state_r == ST_IDLE);
    cmd.use_hold   = (state_r == ST_HOLD);
    go             = (state_r == ST_HOLD) || (state_r == ST_IDLE && in_valid);
    case (state_r)
      ST_IDLE, ST_HOLD: begin
        if (go) begin
          if (p_emit && !status.can_emit) begin
            cmd.hold_load = (state_r == ST_IDLE);
            state_nxt     = ST_HOLD;
          end else begin
            cmd.emit            = p_emit;
            cmd.emit_kind       = p_kind;
            cmd.emit_err        = p_err;
            cmd.emit_bsel       = p_bsel;
            cmd.emit_start_line = p_start_line;
            cmd.emit_last       = p_last;
            cmd.count_line      = p_count;
            cmd.name_add        = p_add;
            cmd.name_clear      = p_clear;
            cmd.set_text_start  = p_text_start;
            cmd.line_reset      = p_reset;
            cmd.rd_start        = p_flush;
            mode_nxt            = p_mode;
            tail_v_nxt          = p_tail_v;
            tail_kind_nxt       = p_tail_kind;
            tail_count_nxt      = p_tail_count;
            if (p_flush) begin
              state_nxt = ST_FLUSH;
            end else if (p_tail_v) begin
              state_nxt = ST_TAIL;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (status.can_emit) begin
          cmd.emit = 1'b1;
          if (status.kw_match || status.flush_last) begin
            cmd.name_clear = 1'b1;
            cmd.emit_last  = !tail_v_r;
            state_nxt      = tail_v_r ? ST_TAIL : ST_IDLE;
          end
          if (status.kw_match) begin
            cmd.emit_kind = status.kw_kind;
          end else begin
            cmd.emit_kind  = TK_VAR;
            cmd.emit_bsel  = BS_NAME;
            cmd.rd_advance = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (status.can_emit) begin
          cmd.emit       = 1'b1;
          cmd.emit_kind  = tail_kind_r;
          cmd.emit_last  = 1'b1;
          cmd.count_line = tail_count_r;
          tail_v_nxt     = 1'b0;
          state_nxt      = ST_IDLE;
          if (tail_kind_r == TK_EXIT) begin
            cmd.line_reset = 1'b1;
            cmd.name_clear = 1'b1;
            mode_nxt       = MD_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MD_IDLE;
      tail_v_r     <= 1'b0;
      tail_kind_r  <= TK_VAR;
      tail_count_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      tail_v_r     <= tail_v_nxt;
      tail_kind_r  <= tail_kind_nxt;
      tail_count_r <= tail_count_nxt;
    end
  end

endmodule

[rtl/stl_datapath.sv]
// Lexer datapath: byte classifier, hold register, name buffer memory,
// keyword match, line counters and output register. Depends on stl_pkg.
module stl_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [stl_pkg::BYTE_W-1:0]         in_byte,
  input  logic                               in_eoi,
  input  stl_pkg::cmd_t                      cmd,
  output stl_pkg::status_t                   status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [stl_pkg::TOKEN_W-1:0]        out_token_kind,
  output logic [stl_pkg::BYTE_W-1:0]         out_text_byte,
  output logic                               out_has_byte,
  output logic [stl_pkg::LINE_OUT_W-1:0]     out_line_number,
  output logic [stl_pkg::ERR_W-1:0]          out_error_code,
  output logic                               out_last
);
  import stl_pkg::*;

  logic [BYTE_W-1:0]     hold_byte_r;
  logic                  hold_eoi_r;
  logic [BYTE_W-1:0]     cur_byte, cur_lower;
  logic                  cur_eoi;
  byte_class_t           cur_class;

  logic [BYTE_W-1:0]     name_mem [MAX_NAME];
  logic [NAME_LEN_W-1:0] name_len_r, name_len_nxt;
  logic [NUM_KW-1:0]     hits_r, hits_nxt, hit_mask;
  logic [NAME_IDX_W-1:0] rd_ptr_r, rd_addr;
  logic [BYTE_W-1:0]     rd_data_r;
  logic                  kw_match;
  token_t                kw_kind;
  logic [KW_COLS*BYTE_W-1:0] kw_row;
  logic [BYTE_W-1:0]     kw_ch;

  logic [LINE_BITS-1:0]  line_cnt_r, line_cnt_nxt, line_inc, text_start_r, line_val;
  logic [LINE_OUT_W+LINE_BITS-1:0] line_ext;

  logic                  out_valid_r;
  token_t                out_kind_r;
  logic [BYTE_W-1:0]     out_byte_r;
  logic                  out_has_r;
  logic [LINE_OUT_W-1:0] out_line_r;
  err_t                  out_err_r;
  logic                  out_last_r;

  assign cur_byte  = cmd.use_hold ? hold_byte_r : in_byte;
  assign cur_eoi   = cmd.use_hold ? hold_eoi_r : in_eoi;
  assign cur_lower = (cur_byte >= "A" && cur_byte <= "Z") ? cur_byte + 8'd32 : cur_byte;

  always_comb begin
    case (cur_byte)
      CH_TAB, CH_CR, CH_SP: cur_class = BC_SPACE;
      CH_HASH:              cur_class = BC_HASH;
      CH_QUOTE:             cur_class = BC_QUOTE;
      CH_NL:                cur_class = BC_NL;
      CH_BRACE_OP:          cur_class = BC_BRACE_OP;
      CH_BRACE_CL:          cur_class = BC_BRACE_CL;
      CH_EQ:                cur_class = BC_EQ;
      CH_COMMA:             cur_class = BC_COMMA;
      CH_DOT:               cur_class = BC_DOT;
      default: begin
        if ((cur_byte >= "0" && cur_byte <= "9") || (cur_lower >= "a" && cur_lower <= "z")) begin
          cur_class = BC_ALNUM;
        end else begin
          cur_class = BC_OTHER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold_byte_r <= in_byte;
      hold_eoi_r  <= in_eoi;
    end
  end

  // keyword hit update for the byte landing at position name_len_r
  always_comb begin
    kw_row = '0;
    kw_ch  = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      kw_row      = KW_TEXT[k];
      kw_ch       = kw_row[(KW_COLS - 1 - int'(name_len_r[KW_COL_W-1:0])) * BYTE_W +: BYTE_W];
      hit_mask[k] = !((name_len_r >= NAME_LEN_W'(KW_LEN[k])) || (cur_lower != kw_ch));
    end
  end

  always_comb begin
    kw_match = 1'b0;
    kw_kind  = TK_BG;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (hits_r[k] && NAME_LEN_W'(KW_LEN[k]) == name_len_r) begin
        kw_match = 1'b1;
        kw_kind  = TK_BG + TOKEN_W'(k);
      end
    end
  end

  always_comb begin
    name_len_nxt = name_len_r;
    hits_nxt     = hits_r;
    if (cmd.name_clear) begin
      name_len_nxt = '0;
      hits_nxt     = '1;
    end else if (cmd.name_add) begin
      name_len_nxt = name_len_r + NAME_LEN_W'(1);
      hits_nxt     = hits_r & hit_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_len_r <= '0;
      hits_r     <= '1;
    end else begin
      name_len_r <= name_len_nxt;
      hits_r     <= hits_nxt;
    end
  end

  always_comb begin
    if (cmd.rd_start) begin
      rd_addr = '0;
    end else if (cmd.rd_advance) begin
      rd_addr = rd_ptr_r + NAME_IDX_W'(1);
    end else begin
      rd_addr = rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.name_add) begin
      name_mem[name_len_r[NAME_IDX_W-1:0]] <= cur_byte;
    end
    rd_data_r <= name_mem[rd_addr];
    rd_ptr_r  <= rd_addr;
  end

  // line counters, saturating
  assign line_inc = (line_cnt_r == '1) ? line_cnt_r : line_cnt_r + LINE_BITS'(1);

  always_comb begin
    if (cmd.line_reset) begin
      line_cnt_nxt = '0;
    end else if (cmd.count_line) begin
      line_cnt_nxt = line_inc;
    end else begin
      line_cnt_nxt = line_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r   <= '0;
      text_start_r <= '0;
    end else begin
      line_cnt_r <= line_cnt_nxt;
      if (cmd.line_reset) begin
        text_start_r <= '0;
      end else if (cmd.set_text_start) begin
        text_start_r <= line_cnt_r;
      end
    end
  end

  always_comb begin
    if (cmd.emit_start_line) begin
      line_val = text_start_r;
    end else if (cmd.count_line) begin
      line_val = line_inc;
    end else begin
      line_val = line_cnt_r;
    end
    line_ext = {LINE_OUT_W'(0), line_val};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r <= cmd.emit_kind;
      out_line_r <= line_ext[LINE_OUT_W-1:0];
      out_err_r  <= cmd.emit_err;
      out_last_r <= cmd.emit_last;
      case (cmd.emit_bsel)
        BS_ITEM: begin
          out_byte_r <= cur_byte;
          out_has_r  <= 1'b1;
        end
        BS_NAME: begin
          out_byte_r <= rd_data_r;
          out_has_r  <= 1'b1;
        end
        default: begin
          out_byte_r <= '0;
          out_has_r  <= 1'b0;
        end
      endcase
    end
  end

  assign status.cur_class  = cur_class;
  assign status.cur_eoi    = cur_eoi;
  assign status.name_nz    = (name_len_r != '0);
  assign status.name_full  = (name_len_r >= NAME_LEN_W'(MAX_NAME));
  assign status.kw_match   = kw_match;
  assign status.kw_kind    = kw_kind;
  assign status.flush_last = (NAME_LEN_W'(rd_ptr_r) + NAME_LEN_W'(1)) == name_len_r;
  assign status.can_emit   = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_token_kind  = out_kind_r;
  assign out_text_byte   = out_byte_r;
  assign out_has_byte    = out_has_r;
  assign out_line_number = out_line_r;
  assign out_error_code  = out_err_r;
  assign out_last        = out_last_r;

endmodule
